[hdl/lae_pkg.sv]
// Shared constants, types and command/status bundles for the line assembler.
package lae_pkg;

  // Line store geometry
  localparam int LINE_DEPTH = 32;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CNT_W      = 6;

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT  = 1'd1;

  // Register reset values
  localparam logic [CNT_W-1:0] LINE_LIMIT_RST = 6'd32;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BS = 8'h08;
  localparam logic [BYTE_W-1:0] CH_SP = 8'h20;

  // Source of an outgoing result byte
  typedef enum logic [2:0] {
    SRC_ECHO,
    SRC_BS,
    SRC_SP,
    SRC_CR,
    SRC_LF,
    SRC_LINE,
    SRC_NL
  } lae_src_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     latch_byte;
    logic     clr_fill;
    logic     dec_fill;
    logic     store;
    logic     latch_len;
    logic     clr_idx;
    logic     inc_idx;
    logic     rd_en;
    logic     emit;
    lae_src_e src;
    logic     last;
  } lae_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_eol;
    logic is_bs;
    logic echo;
    logic fill_zero;
    logic full;
    logic idx_end;
    logic out_free;
  } lae_sts_t;

endpackage

[hdl/lae_ifs.sv]
// Valid/ready channel interfaces: received bytes, results and register writes.
interface lae_rx_if;
  import lae_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lae_tx_if;
  import lae_pkg::*;
  logic              valid;
  logic              ready;
  logic              out_kind;
  logic [BYTE_W-1:0] out_byte;
  logic              last;
  logic [CNT_W-1:0]  line_length;

  modport source (output valid, output out_kind, output out_byte, output last,
                  output line_length, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input last,
                  input line_length, output ready);
endinterface

interface lae_cfg_if;
  import lae_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/lae_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, hold data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/lae_ctrl.sv]
// Sequencing state machine: decodes each byte and steps out its results.
module lae_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rx_valid_i,
  output logic              rx_ready_o,
  input  lae_pkg::lae_sts_t sts_i,
  output lae_pkg::lae_cmd_t cmd_o
);
  import lae_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_ECHO_C  = 4'd2;
  localparam logic [3:0] S_BS1     = 4'd3;
  localparam logic [3:0] S_BS2     = 4'd4;
  localparam logic [3:0] S_BS3     = 4'd5;
  localparam logic [3:0] S_ECHO_CR = 4'd6;
  localparam logic [3:0] S_ECHO_LF = 4'd7;
  localparam logic [3:0] S_RD      = 4'd8;
  localparam logic [3:0] S_LINE    = 4'd9;
  localparam logic [3:0] S_NL      = 4'd10;

  logic [3:0] state_q, state_d;
  lae_cmd_t   cmd;

  assign rx_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    cmd.src = SRC_ECHO;
    case (state_q)
      S_IDLE: begin
        if (rx_valid_i) begin
          cmd.latch_byte = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_eol) begin
          cmd.clr_fill = 1'b1;
          if (!sts_i.fill_zero) begin
            cmd.latch_len = 1'b1;
            cmd.clr_idx   = 1'b1;
            state_d       = sts_i.echo ? S_ECHO_CR : S_RD;
          end else begin
            state_d = S_IDLE;
          end
        end else if (sts_i.is_bs) begin
          if (!sts_i.fill_zero) begin
            cmd.dec_fill = 1'b1;
            state_d      = S_BS1;
          end else begin
            state_d = S_IDLE;
          end
        end else if (sts_i.full) begin
          // flush and drop the byte
          cmd.clr_fill = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd.store = 1'b1;
          state_d   = sts_i.echo ? S_ECHO_C : S_IDLE;
        end
      end
      S_ECHO_C: begin
        if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.src  = SRC_ECHO;
          cmd.last = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_BS1: begin
        if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.src  = SRC_BS;
          state_d  = S_BS2;
        end
      end
      S_BS2: begin
        if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.src  = SRC_SP;
          state_d  = S_BS3;
        end
      end
      S_BS3: begin
        if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.src  = SRC_BS;
          cmd.last = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_ECHO_CR: begin
        if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.src  = SRC_CR;
          state_d  = S_ECHO_LF;
        end
      end
      S_ECHO_LF: begin
        if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.src  = SRC_LF;
          state_d  = S_RD;
        end
      end
      S_RD: begin
        // fetch the next stored byte
        cmd.rd_en = 1'b1;
        state_d   = S_LINE;
      end
      S_LINE: begin
        if (sts_i.out_free) begin
          cmd.emit    = 1'b1;
          cmd.src     = SRC_LINE;
          cmd.inc_idx = 1'b1;
          state_d     = sts_i.idx_end ? S_NL : S_RD;
        end
      end
      S_NL: begin
        if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.src  = SRC_NL;
          cmd.last = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/lae_dp.sv]
// Datapath: registers, fill count, line store and the output register.
module lae_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lae_pkg::BYTE_W-1:0]     rx_byte_i,
  input  logic                           cfg_we_i,
  input  logic [lae_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lae_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  lae_pkg::lae_cmd_t              cmd_i,
  output lae_pkg::lae_sts_t              sts_o,
  input  logic                           tx_ready_i,
  output logic                           tx_valid_o,
  output logic                           out_kind_o,
  output logic [lae_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                           last_o,
  output logic [lae_pkg::CNT_W-1:0]      line_length_o
);
  import lae_pkg::*;

  logic              echo_q;
  logic [CNT_W-1:0]  limit_q;
  logic [BYTE_W-1:0] byte_q;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  len_q;
  logic [ADDR_W-1:0] idx_q;
  logic [CNT_W-1:0]  eff_limit;
  logic [BYTE_W-1:0] rd_data;

  logic              ov_q;
  logic              kind_q, last_q;
  logic [BYTE_W-1:0] obyte_q;
  logic [CNT_W-1:0]  olen_q;
  logic              kind_d;
  logic [BYTE_W-1:0] obyte_d;
  logic [CNT_W-1:0]  olen_d;
  logic              out_free;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q  <= 1'b0;
      limit_q <= LINE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ECHO_ENABLE: echo_q  <= cfg_data_i[0];
        REG_LINE_LIMIT:  limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the limit to the store depth
  assign eff_limit = (limit_q > CNT_W'(LINE_DEPTH)) ? CNT_W'(LINE_DEPTH) : limit_q;

  // Hold the accepted byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_byte) begin
      byte_q <= rx_byte_i;
    end
  end

  // Fill count
  always_comb begin
    fill_d = fill_q;
    if (cmd_i.clr_fill) begin
      fill_d = '0;
    end else if (cmd_i.dec_fill) begin
      fill_d = fill_q - CNT_W'(1);
    end else if (cmd_i.store) begin
      fill_d = fill_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Line length and read index for delivery
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      idx_q <= '0;
    end else begin
      if (cmd_i.latch_len) begin
        len_q <= fill_q;
      end
      if (cmd_i.clr_idx) begin
        idx_q <= '0;
      end else if (cmd_i.inc_idx) begin
        idx_q <= idx_q + ADDR_W'(1);
      end
    end
  end

  lae_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i (byte_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  // Status towards the controller
  assign out_free        = !ov_q || tx_ready_i;
  assign sts_o.is_eol    = (byte_q == CH_CR) || (byte_q == CH_LF);
  assign sts_o.is_bs     = echo_q && (byte_q == CH_BS);
  assign sts_o.echo      = echo_q;
  assign sts_o.fill_zero = (fill_q == '0);
  assign sts_o.full      = (fill_q >= eff_limit);
  assign sts_o.idx_end   = ((CNT_W'(idx_q) + CNT_W'(1)) == len_q);
  assign sts_o.out_free  = out_free;

  // Select the outgoing byte
  always_comb begin
    kind_d  = 1'b0;
    obyte_d = byte_q;
    olen_d  = '0;
    case (cmd_i.src)
      SRC_ECHO: obyte_d = byte_q;
      SRC_BS:   obyte_d = CH_BS;
      SRC_SP:   obyte_d = CH_SP;
      SRC_CR:   obyte_d = CH_CR;
      SRC_LF:   obyte_d = CH_LF;
      SRC_LINE: begin
        kind_d  = 1'b1;
        obyte_d = rd_data;
      end
      SRC_NL: begin
        kind_d  = 1'b1;
        obyte_d = CH_LF;
        olen_d  = len_q + CNT_W'(1);
      end
      default: obyte_d = byte_q;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ov_q <= 1'b1;
    end else if (tx_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q  <= kind_d;
      obyte_q <= obyte_d;
      last_q  <= cmd_i.last;
      olen_q  <= olen_d;
    end
  end

  assign tx_valid_o    = ov_q;
  assign out_kind_o    = kind_q;
  assign out_byte_o    = obyte_q;
  assign last_o        = last_q;
  assign line_length_o = olen_q;

endmodule

[hdl/line_assembler_with_echo.sv]
// A byte is decoded in the cycle after it is accepted; its results are then loaded into the
//   output register one by one, each waiting while the output register is full and stalled.
//   The next byte is taken only once the results of the last one have all been loaded.
// Line delivery reads each stored byte through the store's registered read port before loading it.
// Reset clears the fill count, the registers (echo off, limit 32) and the output stage;
//   the line store itself is not cleared.
module line_assembler_with_echo (
  input  logic     clk_i,
  input  logic     rst_ni,
  lae_rx_if.sink   rx_i,
  lae_tx_if.source tx_o,
  lae_cfg_if.sink  cfg_i
);
  import lae_pkg::*;

  lae_cmd_t cmd;
  lae_sts_t sts;

  // Register writes are always taken
  assign cfg_i.ready = 1'b1;

  lae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .rx_ready_o (rx_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lae_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_i.rx_byte),
    .cfg_we_i      (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .tx_ready_i    (tx_o.ready),
    .tx_valid_o    (tx_o.valid),
    .out_kind_o    (tx_o.out_kind),
    .out_byte_o    (tx_o.out_byte),
    .last_o        (tx_o.last),
    .line_length_o (tx_o.line_length)
  );

endmodule

[hdl/lae_chk.sv]
// Port-level checker for the line assembler, bound to the top level.
module lae_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         rx_valid_i,
  input logic                         rx_ready_i,
  input logic                         tx_valid_i,
  input logic                         tx_ready_i,
  input logic                         out_kind_i,
  input logic [lae_pkg::BYTE_W-1:0]   out_byte_i,
  input logic                         last_i,
  input logic [lae_pkg::CNT_W-1:0]    line_length_i
);
  import lae_pkg::*;

  // A stalled result holds
  a_tx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_i && !tx_ready_i |=> tx_valid_i && $stable(out_byte_i) && $stable(last_i))
    else $error("result changed while stalled");

  // One byte at a time: no transaction right after an accepted byte
  a_rx_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_valid_i && rx_ready_i |=> !rx_ready_i)
    else $error("input taken while a byte is decoded");

  // A length appears only on the closing newline of a line
  a_len_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_i && (line_length_i != '0) |->
      last_i && out_kind_i && (out_byte_i == CH_LF) && (line_length_i > CNT_W'(1)))
    else $error("line length on a result that does not close a line");

  // A final line byte always carries its length
  a_nl_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_i && out_kind_i && last_i |-> (line_length_i != '0))
    else $error("closing newline without a length");

endmodule

bind line_assembler_with_echo lae_chk u_lae_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rx_valid_i    (rx_i.valid),
  .rx_ready_i    (rx_i.ready),
  .tx_valid_i    (tx_o.valid),
  .tx_ready_i    (tx_o.ready),
  .out_kind_i    (tx_o.out_kind),
  .out_byte_i    (tx_o.out_byte),
  .last_i        (tx_o.last),
  .line_length_i (tx_o.line_length)
);

[sim/line_assembler_with_echo_tb.sv]
// Testbench for line_assembler_with_echo: directed and random byte streams against a predictor.
`timescale 1ns / 1ps

module line_assembler_with_echo_tb;
  import lae_pkg::*;

  localparam logic KIND_ECHO    = 1'b0;
  localparam logic KIND_LINE    = 1'b1;
  localparam int   RANDOM_ITEMS = 76;
  localparam int   IDLE_SETTLE  = 80;    // settle after the last result before reconfiguring
  localparam int   QUIET_LIMIT  = 1000;  // cycles without any transaction

  typedef struct {
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [CNT_W-1:0]  len;
  } tx_byte_t;

  logic clk_i;
  logic rst_ni;

  lae_rx_if  rx_ch ();
  lae_tx_if  tx_ch ();
  lae_cfg_if cfg_ch ();

  line_assembler_with_echo dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_ch),
    .tx_o   (tx_ch),
    .cfg_i  (cfg_ch)
  );

  // Predictor state
  logic [BYTE_W-1:0] line_copy [LINE_DEPTH];
  int                fill_count;
  logic              echo_on;
  logic [CNT_W-1:0]  limit_reg;
  tx_byte_t          tx_due_q [$];

  int mismatches;
  int bytes_effective;
  bit rx_gaps_on;
  bit tx_stalls_on;
  int quiet_cycles;

  // Clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void queue_tx(input logic kind, input logic [BYTE_W-1:0] data,
                                   input logic last, input logic [CNT_W-1:0] len);
    tx_byte_t t;
    t.kind = kind;
    t.data = data;
    t.last = last;
    t.len  = len;
    tx_due_q.push_back(t);
  endfunction

  // Work out the results of one received byte; return 1 when the block ignores it
  function automatic bit assemble_byte(input logic [BYTE_W-1:0] c);
    int cap;
    int n;
    int i;
    cap = (int'(limit_reg) > LINE_DEPTH) ? LINE_DEPTH : int'(limit_reg);
    if (c == CH_CR || c == CH_LF) begin
      n = fill_count;
      fill_count = 0;
      if (n == 0) return 1'b1;
      if (echo_on) begin
        queue_tx(KIND_ECHO, CH_CR, 1'b0, '0);
        queue_tx(KIND_ECHO, CH_LF, 1'b0, '0);
      end
      for (i = 0; i < n; i++) queue_tx(KIND_LINE, line_copy[i], 1'b0, '0);
      queue_tx(KIND_LINE, CH_LF, 1'b1, CNT_W'(n + 1));
      return 1'b0;
    end
    // Backspace editing only while echo is on
    if (echo_on && c == CH_BS) begin
      if (fill_count == 0) return 1'b1;
      fill_count--;
      queue_tx(KIND_ECHO, CH_BS, 1'b0, '0);
      queue_tx(KIND_ECHO, CH_SP, 1'b0, '0);
      queue_tx(KIND_ECHO, CH_BS, 1'b1, '0);
      return 1'b0;
    end
    // Full buffer: flush and drop
    if (fill_count >= cap) begin
      fill_count = 0;
      return 1'b0;
    end
    line_copy[fill_count % LINE_DEPTH] = c;
    fill_count++;
    if (echo_on) queue_tx(KIND_ECHO, c, 1'b1, '0);
    return 1'b0;
  endfunction

  // Check each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    tx_byte_t want;
    if (rst_ni && tx_ch.valid && tx_ch.ready) begin
      if (tx_due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                  tx_ch.out_kind, tx_ch.out_byte));
      end else begin
        want = tx_due_q.pop_front();
        if (tx_ch.out_kind !== want.kind)
          report_mismatch($sformatf("out_kind %0d, want %0d", tx_ch.out_kind, want.kind));
        if (tx_ch.out_byte !== want.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", tx_ch.out_byte, want.data));
        if (tx_ch.last !== want.last)
          report_mismatch($sformatf("last %0d, want %0d", tx_ch.last, want.last));
        if (tx_ch.line_length !== want.len)
          report_mismatch($sformatf("line_length %0d, want %0d", tx_ch.line_length, want.len));
      end
    end
  end

  // Result side: stall a random number of cycles before each transaction
  initial begin
    int stall;
    tx_ch.ready  = 1'b0;
    tx_stalls_on = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = tx_stalls_on ? $urandom_range(0, 11) : 0;
      if ($urandom_range(0, 15) == 0) tx_stalls_on = !tx_stalls_on;
      if (stall > 0) begin
        tx_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      tx_ch.ready = 1'b1;
      do @(posedge clk_i); while (!tx_ch.valid);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Send one received byte after a random gap and predict its results
  task automatic send_rx_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = rx_gaps_on ? $urandom_range(0, 11) : 0;
    if ($urandom_range(0, 15) == 0) rx_gaps_on = !rx_gaps_on;
    @(negedge clk_i);
    if (gap > 0) begin
      rx_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_ch.valid   = 1'b1;
    rx_ch.rx_byte = b;
    do @(posedge clk_i); while (!rx_ch.ready);
    if (!assemble_byte(b)) bytes_effective++;
  endtask

  // Drop valid, wait for every expected result, then let the block settle
  task automatic drain_results(input int settle);
    @(negedge clk_i);
    rx_ch.valid = 1'b0;
    while (tx_due_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    if (idx == REG_ECHO_ENABLE) echo_on = val[0];
    else limit_reg = val;
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  // Reconfigure only once the block has gone idle
  task automatic set_config(input logic echo, input logic [CNT_W-1:0] limit);
    drain_results(IDLE_SETTLE);
    write_reg(REG_ECHO_ENABLE, CFG_DATA_W'(echo));
    write_reg(REG_LINE_LIMIT, limit);
  endtask

  // Reset settings: echo off, so backspace is stored and nothing is echoed
  task automatic test_echo_off_lines();
    send_rx_byte(8'h00);
    send_rx_byte(8'hFF);
    send_rx_byte(CH_BS);
    send_rx_byte(CH_CR);
    send_rx_byte(CH_LF);   // empty line gives nothing
  endtask

  // Echo on: echoed bytes, backspace editing and backspace at an empty buffer
  task automatic test_echo_editing();
    set_config(1'b1, 6'd32);
    send_rx_byte("a");
    send_rx_byte(CH_BS);
    send_rx_byte(CH_BS);   // nothing left to remove
    send_rx_byte("b");
    send_rx_byte("c");
    send_rx_byte(CH_BS);
    send_rx_byte(CH_LF);
  endtask

  // Small, zero and lowered limits
  task automatic test_line_limits();
    set_config(1'b1, 6'd1);
    send_rx_byte("x");
    send_rx_byte("y");     // buffer full: flush and drop
    send_rx_byte(CH_CR);
    set_config(1'b0, 6'd0);
    send_rx_byte("z");
    send_rx_byte(CH_CR);
    set_config(1'b0, 6'd32);
    send_rx_byte("p");
    send_rx_byte("q");
    send_rx_byte("r");
    set_config(1'b0, 6'd2); // limit now below the count
    send_rx_byte("s");
    send_rx_byte(CH_LF);
  endtask

  // Random lines: mostly printable text with edits, some noise and unterminated lines
  task automatic test_random_lines();
    int line_no;
    int len;
    int pick;
    int k;
    logic [CNT_W-1:0] limit;
    logic [BYTE_W-1:0] b;
    set_config(1'b1, 6'd63);
    line_no = 0;
    bytes_effective = 0;
    while (bytes_effective < RANDOM_ITEMS) begin
      if (line_no >= 2 && line_no % 3 == 0) begin
        case ($urandom_range(0, 7))
          0:       limit = 6'd0;
          1:       limit = 6'd1;
          2:       limit = 6'd32;
          3:       limit = 6'd33;
          4:       limit = 6'd63;
          default: limit = CNT_W'($urandom_range(2, 31));
        endcase
        set_config(1'($urandom_range(0, 1)), limit);
      end
      // First a full line, then one that overruns the store
      if (line_no == 0) len = 32;
      else if (line_no == 1) len = 33;
      else if ($urandom_range(0, 7) == 0) len = $urandom_range(28, 35);
      else len = $urandom_range(0, 8);
      for (k = 0; k < len; k++) begin
        pick = (line_no < 2) ? 15 : $urandom_range(0, 15);
        if (pick == 0) b = BYTE_W'($urandom_range(0, 255));
        else if (pick <= 2) b = CH_BS;
        else b = BYTE_W'($urandom_range(8'h20, 8'h7E));
        send_rx_byte(b);
      end
      if ($urandom_range(0, 9) != 0) send_rx_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
      line_no++;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    mismatches    = 0;
    rx_gaps_on    = 1'b1;
    quiet_cycles  = 0;
    fill_count    = 0;
    echo_on       = 1'b0;
    limit_reg     = LINE_LIMIT_RST;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_echo_off_lines();
    test_echo_editing();
    test_line_limits();
    test_random_lines();
    drain_results(IDLE_SETTLE);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/lae_pkg.sv
hdl/lae_ifs.sv
hdl/lae_ram.sv
hdl/lae_ctrl.sv
hdl/lae_dp.sv
hdl/line_assembler_with_echo.sv
hdl/lae_chk.sv
sim/line_assembler_with_echo_tb.sv
